### hdl/abt_pkg.sv
// Package for the array binary tree engine: item types, codes and the control store.
`timescale 1ns / 1ps

package abt_pkg;

  // Default sizes of the tree store
  localparam int DEF_TREE_LEVELS = 4;
  localparam int DEF_VALUE_WIDTH = 16;

  // Fixed field widths of the item channels
  localparam int MODE_W  = 2;
  localparam int FIELD_W = 16;
  localparam int PATH_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int STAT_W  = 2;

  // Operation modes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [FIELD_W-1:0] value;
    logic [PATH_W-1:0]  path_bits;
    logic [SLOT_W-1:0]  read_slot;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot_index;
    logic [FIELD_W-1:0] slot_value;
  } out_item_t;

  // Datapath action of one control word
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_IDLE,
    ACT_CLR,
    ACT_DESCEND,
    ACT_INC,
    ACT_SET_TOP,
    ACT_WIPE,
    ACT_WR_INS,
    ACT_RES_FULL,
    ACT_RES_FOUND,
    ACT_RES_MISS,
    ACT_RES_DEL,
    ACT_RES_READ,
    ACT_RES_BADRD
  } act_t;

  // Jump condition of one control word
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_PTR_OUT,
    C_PTR_NOT_LAST,
    C_RD_ZERO,
    C_RD_MATCH,
    C_RD_OUT
  } cond_t;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
    logic  fin;
  } ctl_t;

  // Control store addresses
  localparam upc_t U_CLR       = 5'd0;
  localparam upc_t U_IDLE      = 5'd1;
  localparam upc_t U_INS       = 5'd2;
  localparam upc_t U_INS_TEST  = 5'd3;
  localparam upc_t U_INS_DOWN  = 5'd4;
  localparam upc_t U_INS_FULL  = 5'd5;
  localparam upc_t U_INS_WR    = 5'd6;
  localparam upc_t U_SRCH      = 5'd7;
  localparam upc_t U_SRCH_TEST = 5'd8;
  localparam upc_t U_SRCH_NEXT = 5'd9;
  localparam upc_t U_SRCH_HIT  = 5'd10;
  localparam upc_t U_MISS      = 5'd11;
  localparam upc_t U_DEL       = 5'd12;
  localparam upc_t U_DEL_TEST  = 5'd13;
  localparam upc_t U_DEL_NEXT  = 5'd14;
  localparam upc_t U_DEL_TOP   = 5'd15;
  localparam upc_t U_WIPE      = 5'd16;
  localparam upc_t U_WIPE_STEP = 5'd17;
  localparam upc_t U_DEL_DONE  = 5'd18;
  localparam upc_t U_READ      = 5'd19;
  localparam upc_t U_READ_OK   = 5'd20;
  localparam upc_t U_READ_BAD  = 5'd21;

  function automatic ctl_t uw(act_t a, cond_t c, upc_t t, logic f);
    ctl_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    w.fin    = f;
    return w;
  endfunction

  // Control store: a false condition falls through to the next word
  function automatic ctl_t ucode_rom(upc_t addr);
    ctl_t w;
    unique case (addr)
      U_CLR:       w = uw(ACT_CLR,       C_PTR_NOT_LAST, U_CLR,       1'b0);
      U_IDLE:      w = uw(ACT_IDLE,      C_NEVER,        U_IDLE,      1'b0);
      U_INS:       w = uw(ACT_NONE,      C_PTR_OUT,      U_INS_FULL,  1'b0);
      U_INS_TEST:  w = uw(ACT_NONE,      C_RD_ZERO,      U_INS_WR,    1'b0);
      U_INS_DOWN:  w = uw(ACT_DESCEND,   C_ALWAYS,       U_INS,       1'b0);
      U_INS_FULL:  w = uw(ACT_RES_FULL,  C_ALWAYS,       U_IDLE,      1'b1);
      U_INS_WR:    w = uw(ACT_WR_INS,    C_ALWAYS,       U_IDLE,      1'b1);
      U_SRCH:      w = uw(ACT_NONE,      C_PTR_OUT,      U_MISS,      1'b0);
      U_SRCH_TEST: w = uw(ACT_NONE,      C_RD_MATCH,     U_SRCH_HIT,  1'b0);
      U_SRCH_NEXT: w = uw(ACT_INC,       C_ALWAYS,       U_SRCH,      1'b0);
      U_SRCH_HIT:  w = uw(ACT_RES_FOUND, C_ALWAYS,       U_IDLE,      1'b1);
      U_MISS:      w = uw(ACT_RES_MISS,  C_ALWAYS,       U_IDLE,      1'b1);
      U_DEL:       w = uw(ACT_NONE,      C_PTR_OUT,      U_MISS,      1'b0);
      U_DEL_TEST:  w = uw(ACT_NONE,      C_RD_MATCH,     U_DEL_TOP,   1'b0);
      U_DEL_NEXT:  w = uw(ACT_INC,       C_ALWAYS,       U_DEL,       1'b0);
      U_DEL_TOP:   w = uw(ACT_SET_TOP,   C_NEVER,        U_IDLE,      1'b0);
      U_WIPE:      w = uw(ACT_NONE,      C_PTR_OUT,      U_DEL_DONE,  1'b0);
      U_WIPE_STEP: w = uw(ACT_WIPE,      C_ALWAYS,       U_WIPE,      1'b0);
      U_DEL_DONE:  w = uw(ACT_RES_DEL,   C_ALWAYS,       U_IDLE,      1'b1);
      U_READ:      w = uw(ACT_NONE,      C_RD_OUT,       U_READ_BAD,  1'b0);
      U_READ_OK:   w = uw(ACT_RES_READ,  C_ALWAYS,       U_IDLE,      1'b1);
      U_READ_BAD:  w = uw(ACT_RES_BADRD, C_ALWAYS,       U_IDLE,      1'b1);
      default:     w = uw(ACT_NONE,      C_ALWAYS,       U_IDLE,      1'b0);
    endcase
    return w;
  endfunction

  // Entry point of the program for each mode
  function automatic upc_t ucode_entry(logic [MODE_W-1:0] mode);
    upc_t e;
    unique case (mode)
      MODE_INSERT: e = U_INS;
      MODE_SEARCH: e = U_SRCH;
      MODE_DELETE: e = U_DEL;
      default:     e = U_READ;
    endcase
    return e;
  endfunction

endpackage

### hdl/array_binary_tree_engine_top.sv
// Top level of the array binary tree engine: microcoded sequencer over a slot RAM.
// After reset a clearing pass zeroes the store, one slot a cycle,
// with in_ready low; the sequencer then waits in its idle word with in_ready high.
// Read returns the slot at read_slot; insert follows the path bits to the first empty slot
// or reports full; search and delete scan slots from zero, then delete wipes the subtree.
// One item is worked at a time; the next is taken while the output register waits.
`timescale 1ns / 1ps

module array_binary_tree_engine_top #(
  parameter int TREE_LEVELS = abt_pkg::DEF_TREE_LEVELS,
  parameter int VALUE_WIDTH = abt_pkg::DEF_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  abt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output abt_pkg::out_item_t out_data
);

  import abt_pkg::*;

  localparam int AW         = TREE_LEVELS;
  localparam int PW         = TREE_LEVELS + 1;
  localparam int SLOT_COUNT = (1 << TREE_LEVELS) - 1;
  localparam int CW         = (PW > SLOT_W) ? PW : SLOT_W;

  // Sequencer and datapath registers
  upc_t                upc;
  upc_t                upc_next;
  ctl_t                ctl;
  logic [PW-1:0]       ptr;
  logic [PW-1:0]       ptr_next;
  logic [AW-1:0]       top;
  logic [1:0]          k;
  logic [VALUE_WIDTH-1:0] v_reg;
  logic [PATH_W-1:0]   path_reg;
  logic [SLOT_W-1:0]   rd_reg;

  // RAM ports
  logic                   ram_we;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic                   mark_we;
  logic [0:0]             mark_wdata;
  logic [0:0]             mark_rdata;
  logic [AW-1:0]          parent;

  logic accept;
  logic out_free;
  logic stall;
  logic cond_true;
  logic path_bit;
  logic reach;
  logic wipe_hit;
  logic [CW-1:0] rd_wide;

  assign ctl      = ucode_rom(upc);
  assign in_ready = (ctl.act == ACT_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign stall    = ctl.fin && !out_free;

  // Parent of the slot under the pointer, for the subtree sweep
  assign parent  = AW'((ptr - PW'(1)) >> 1);
  assign reach   = (ptr == PW'(top)) || ((parent >= top) && mark_rdata[0]);
  assign wipe_hit = reach && (ram_rdata != '0);
  assign rd_wide = CW'(rd_reg);

  // Pick the path bit for the current depth; deep paths go left
  always_comb begin
    unique case (k)
      2'd0:    path_bit = path_reg[0];
      2'd1:    path_bit = path_reg[1];
      2'd2:    path_bit = path_reg[2];
      default: path_bit = 1'b0;
    endcase
  end

  // Evaluate the jump condition
  always_comb begin
    unique case (ctl.cond)
      C_NEVER:        cond_true = 1'b0;
      C_ALWAYS:       cond_true = 1'b1;
      C_PTR_OUT:      cond_true = (ptr >= PW'(SLOT_COUNT));
      C_PTR_NOT_LAST: cond_true = (ptr != PW'(SLOT_COUNT - 1));
      C_RD_ZERO:      cond_true = (ram_rdata == '0);
      C_RD_MATCH:     cond_true = (ram_rdata == v_reg);
      C_RD_OUT:       cond_true = (rd_wide >= CW'(SLOT_COUNT));
      default:        cond_true = 1'b0;
    endcase
  end

  // Step the program counter
  always_comb begin
    if (ctl.act == ACT_IDLE) begin
      upc_next = accept ? ucode_entry(in_data.mode) : upc;
    end else if (stall) begin
      upc_next = upc;
    end else if (cond_true) begin
      upc_next = ctl.target;
    end else begin
      upc_next = upc + upc_t'(1);
    end
  end

  // Advance the slot pointer
  always_comb begin
    ptr_next = ptr;
    unique case (ctl.act)
      ACT_IDLE: begin
        if (accept) begin
          ptr_next = (in_data.mode == MODE_READ) ? PW'(in_data.read_slot) : '0;
        end
      end
      ACT_DESCEND:              ptr_next = (ptr << 1) + PW'(1) + PW'(path_bit);
      ACT_INC, ACT_WIPE, ACT_CLR: ptr_next = ptr + PW'(1);
      default:                  ptr_next = ptr;
    endcase
  end

  // Drive the RAM write ports
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (ctl.act)
      ACT_CLR:    ram_we = 1'b1;
      ACT_WR_INS: begin
        ram_we    = !stall;
        ram_wdata = v_reg;
      end
      ACT_WIPE:   ram_we = wipe_hit;
      default:    ram_we = 1'b0;
    endcase
  end

  assign mark_we    = (ctl.act == ACT_WIPE);
  assign mark_wdata = wipe_hit;

  abt_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  abt_ram #(
    .WIDTH (1),
    .DEPTH (SLOT_COUNT)
  ) u_mark (
    .clk   (clk),
    .we    (mark_we),
    .waddr (ptr[AW-1:0]),
    .wdata (mark_wdata),
    .raddr (parent),
    .rdata (mark_rdata)
  );

  // Hold sequencer state, latch the item and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_CLR;
      ptr       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      ptr <= ptr_next;
      if (accept) begin
        k        <= '0;
        v_reg    <= VALUE_WIDTH'(in_data.value);
        path_reg <= in_data.path_bits;
        rd_reg   <= in_data.read_slot;
      end else if (ctl.act == ACT_DESCEND && k != 2'd3) begin
        k <= k + 2'd1;
      end
      if (ctl.act == ACT_SET_TOP) begin
        top <= ptr[AW-1:0];
      end
      if (ctl.fin && out_free) begin
        out_valid <= 1'b1;
        unique case (ctl.act)
          ACT_WR_INS: out_data <= '{ST_DONE, SLOT_W'(ptr), FIELD_W'(v_reg)};
          ACT_RES_FOUND: out_data <= '{ST_FOUND, SLOT_W'(ptr), FIELD_W'(v_reg)};
          ACT_RES_DEL: out_data <= '{ST_DONE, SLOT_W'(top), '0};
          ACT_RES_READ: out_data <= '{ST_DONE, rd_reg, FIELD_W'(ram_rdata)};
          ACT_RES_BADRD: out_data <= '{ST_FULL, rd_reg, '0};
          ACT_RES_FULL: out_data <= '{ST_FULL, '0, '0};
          default: out_data <= '{ST_NOT_FOUND, '0, '0};
        endcase
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // One item at a time: the sequencer leaves idle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("accepted an item while a previous one was in flight");

  // No store write while waiting for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (ctl.act == ACT_IDLE) |-> !ram_we)
    else $error("store written in idle");

  // The subtree sweep never runs above its top slot
  a_wipe_below_top: assert property (@(posedge clk) disable iff (rst)
    (ctl.act == ACT_WIPE) |-> (ptr >= PW'(top)))
    else $error("sweep pointer above subtree top");

  // A miss reports slot zero with an empty value
  a_miss_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_NOT_FOUND) |->
      (out_data.slot_index == '0 && out_data.slot_value == '0))
    else $error("miss result carries slot data");

endmodule

### hdl/abt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module abt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read the array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
